// File: rtl/rars_pkg.sv
`timescale 1ns / 1ps
package rars_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int IDX_W        = 10;
    localparam int SIZE_W       = 11;
    localparam int BIT_W        = 12;
    localparam int DATA_W       = 64;
    localparam int VALUE_W      = 32;
    localparam int FUNC_W       = 2;
    localparam int ADDR_W       = 3;
    localparam int APB_W        = 32;

    localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADD  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SUM  = 2'd2;

    localparam logic [ADDR_W-1:0] REG_ACTIVE_SIZE = 3'd0;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PLAN,
        ST_PF_RD,
        ST_PF_ACC,
        ST_PF_MUL,
        ST_PF_SUB,
        ST_UP_MUL,
        ST_UP_RD,
        ST_UP_WR
    } t_state;

    typedef enum logic [1:0] {
        JOB_NONE,
        JOB_LOAD,
        JOB_ADD,
        JOB_SUM
    } t_job;

    typedef enum logic [1:0] {
        ACT_PREFIX,
        ACT_UPDATE,
        ACT_FINISH
    } t_act;

endpackage

// File: rtl/rars_if.sv
`timescale 1ns / 1ps
interface rars_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [rars_pkg::FUNC_W-1:0]          func;
    logic [rars_pkg::IDX_W-1:0]           lo;
    logic [rars_pkg::IDX_W-1:0]           hi;
    logic signed [rars_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output func, output lo, output hi, output value,
                    input ready);
    modport sink (input valid, input func, input lo, input hi, input value,
                  output ready);
endinterface

interface rars_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [rars_pkg::DATA_W-1:0]   sum;

    modport source (output valid, output sum, input ready);
    modport sink (input valid, input sum, output ready);
endinterface

// File: rtl/range_add_range_sum_tree.sv
`timescale 1ns / 1ps
// Channel   Dir  Payload                      Transfer
// i_in      in   func, lo, hi, value          valid & ready
// o_out     out  sum                          valid & ready
// apb       in   active_size at byte addr 0   psel & penable & pwrite
//
// The array is held as two binary indexed trees in one 1024 x 128 memory.
// Each tree node is read and then accumulated or written back; sums, adds and loads
// all go through the single memory port and share one multiplier.
// After reset and after every active_size write, a clearing pass over all 1024
// entries runs before the next input transfer is accepted.
// A result waits in the output register; a new item may start meanwhile.
module range_add_range_sum_tree (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    rars_in_if.sink                         i_in,
    rars_out_if.source                      o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rars_pkg::ADDR_W-1:0]     paddr,
    input  logic [rars_pkg::APB_W-1:0]      pwdata,
    output logic [rars_pkg::APB_W-1:0]      prdata,
    output logic                            pready
);

    localparam int DW = rars_pkg::DATA_W;
    localparam int BW = rars_pkg::BIT_W;
    localparam int IW = rars_pkg::IDX_W;
    localparam int SW = rars_pkg::SIZE_W;

    rars_pkg::t_state r_state, n_state;
    rars_pkg::t_job   r_job;

    logic [SW-1:0]   r_size;
    logic [IW-1:0]   r_clr;
    logic [IW-1:0]   r_lo;
    logic [IW-1:0]   r_r;
    logic [SW-1:0]   r_n;
    logic [DW-1:0]   r_v;
    logic [2:0]      r_step;
    logic [BW-1:0]   r_j;
    logic [BW-1:0]   r_uidx;
    logic [DW-1:0]   r_acc1;
    logic [DW-1:0]   r_acc2;
    logic [DW-1:0]   r_prod;
    logic [DW-1:0]   r_pval;
    logic [DW-1:0]   r_pa;
    logic [DW-1:0]   r_dlt;
    logic [DW-1:0]   r_out;
    logic            r_ov;
    logic [2*DW-1:0] r_rd;
    logic [2*DW-1:0] r_tree [0:rars_pkg::MAX_ELEMENTS-1];

    logic            cfg_wr;
    logic            in_xfer;
    logic            out_free;
    logic [SW-1:0]   sz_use;
    logic [SW-1:0]   n_last;
    logic            lo_ok;
    logic [IW-1:0]   hi_clip;
    logic            rng_empty;
    logic [BW-1:0]   j_low;
    logic [BW-1:0]   j_m1;
    logic [DW-1:0]   mul_a;
    logic [SW-1:0]   mul_b;
    logic [DW+SW-1:0] mul_p;
    rars_pkg::t_act  plan_act;
    logic [BW-1:0]   plan_idx;
    logic [DW-1:0]   plan_dlt;
    logic [DW-1:0]   plan_res;
    logic            mem_we;
    logic [IW-1:0]   mem_addr;
    logic [2*DW-1:0] mem_wdata;

    assign cfg_wr   = psel & penable & pwrite & (paddr[2] == rars_pkg::REG_ACTIVE_SIZE[2]);
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == rars_pkg::REG_ACTIVE_SIZE[2]) ?
                      rars_pkg::APB_W'(r_size) : '0;
    assign in_xfer  = i_in.valid & i_in.ready;
    assign out_free = ~r_ov | o_out.ready;

    always_comb begin
        if (r_size == '0) begin
            sz_use = SW'(1);
        end else if (r_size > SW'(rars_pkg::MAX_ELEMENTS)) begin
            sz_use = SW'(rars_pkg::MAX_ELEMENTS);
        end else begin
            sz_use = r_size;
        end
        n_last    = sz_use - SW'(1);
        lo_ok     = SW'(i_in.lo) < sz_use;
        hi_clip   = (SW'(i_in.hi) > n_last) ? n_last[IW-1:0] : i_in.hi;
        rng_empty = i_in.lo > hi_clip;
    end

    assign j_low = r_j & (~r_j + BW'(1));
    assign j_m1  = r_j - BW'(1);

    always_comb begin
        plan_act = rars_pkg::ACT_FINISH;
        plan_idx = '0;
        plan_dlt = r_v;
        plan_res = '0;
        case (r_job)
            rars_pkg::JOB_SUM: begin
                case (r_step)
                    3'd0: begin
                        plan_act = rars_pkg::ACT_PREFIX;
                        plan_idx = BW'(r_r) + BW'(1);
                    end
                    3'd1: begin
                        plan_act = rars_pkg::ACT_PREFIX;
                        plan_idx = BW'(r_lo);
                    end
                    default: plan_res = r_pa - r_pval;
                endcase
            end
            rars_pkg::JOB_ADD: begin
                case (r_step)
                    3'd0: begin
                        plan_act = rars_pkg::ACT_UPDATE;
                        plan_idx = BW'(r_lo) + BW'(1);
                    end
                    3'd1: begin
                        plan_act = rars_pkg::ACT_UPDATE;
                        plan_idx = BW'(r_r) + BW'(2);
                        plan_dlt = -r_v;
                    end
                    3'd2: begin
                        plan_act = rars_pkg::ACT_PREFIX;
                        plan_idx = BW'(r_n);
                    end
                    default: plan_res = r_pval;
                endcase
            end
            rars_pkg::JOB_LOAD: begin
                case (r_step)
                    3'd0: begin
                        plan_act = rars_pkg::ACT_PREFIX;
                        plan_idx = BW'(r_lo) + BW'(1);
                    end
                    3'd1: begin
                        plan_act = rars_pkg::ACT_PREFIX;
                        plan_idx = BW'(r_lo);
                    end
                    3'd2: begin
                        plan_act = rars_pkg::ACT_UPDATE;
                        plan_idx = BW'(r_lo) + BW'(1);
                        plan_dlt = r_v - (r_pa - r_pval);
                    end
                    3'd3: begin
                        plan_act = rars_pkg::ACT_UPDATE;
                        plan_idx = BW'(r_lo) + BW'(2);
                        plan_dlt = -r_dlt;
                    end
                    default: plan_res = '0;
                endcase
            end
            default: plan_res = '0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            rars_pkg::ST_CLEAR: begin
                if (r_clr == '1) begin
                    n_state = rars_pkg::ST_IDLE;
                end
            end
            rars_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    n_state = rars_pkg::ST_PLAN;
                end
            end
            rars_pkg::ST_PLAN: begin
                case (plan_act)
                    rars_pkg::ACT_PREFIX: n_state = rars_pkg::ST_PF_RD;
                    rars_pkg::ACT_UPDATE: n_state = rars_pkg::ST_UP_MUL;
                    default: begin
                        if (out_free) begin
                            n_state = rars_pkg::ST_IDLE;
                        end
                    end
                endcase
            end
            rars_pkg::ST_PF_RD: begin
                n_state = (r_j == '0) ? rars_pkg::ST_PF_MUL : rars_pkg::ST_PF_ACC;
            end
            rars_pkg::ST_PF_ACC: n_state = rars_pkg::ST_PF_RD;
            rars_pkg::ST_PF_MUL: n_state = rars_pkg::ST_PF_SUB;
            rars_pkg::ST_PF_SUB: n_state = rars_pkg::ST_PLAN;
            rars_pkg::ST_UP_MUL: n_state = rars_pkg::ST_UP_RD;
            rars_pkg::ST_UP_RD: begin
                n_state = (r_j > BW'(rars_pkg::MAX_ELEMENTS)) ?
                          rars_pkg::ST_PLAN : rars_pkg::ST_UP_WR;
            end
            rars_pkg::ST_UP_WR: n_state = rars_pkg::ST_UP_RD;
            default: n_state = rars_pkg::ST_CLEAR;
        endcase
        if (cfg_wr) begin
            n_state = rars_pkg::ST_CLEAR;
        end
    end

    always_comb begin
        i_in.ready  = (r_state == rars_pkg::ST_IDLE);
        o_out.valid = r_ov;
        o_out.sum   = r_out;
        mem_we      = 1'b0;
        mem_addr    = j_m1[IW-1:0];
        mem_wdata   = {r_rd[2*DW-1:DW] + r_prod, r_rd[DW-1:0] + r_dlt};
        mul_a       = r_acc1;
        mul_b       = r_uidx[SW-1:0];
        case (r_state)
            rars_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = r_clr;
                mem_wdata = '0;
            end
            rars_pkg::ST_UP_MUL: begin
                mul_a = r_dlt;
                mul_b = r_uidx[SW-1:0] - SW'(1);
            end
            rars_pkg::ST_UP_WR: mem_we = 1'b1;
            default: mem_we = 1'b0;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_tree[mem_addr] <= mem_wdata;
        end
        r_rd <= r_tree[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rars_pkg::ST_CLEAR;
            r_size  <= SW'(rars_pkg::MAX_ELEMENTS);
            r_clr   <= '0;
            r_ov    <= 1'b0;
            r_job   <= rars_pkg::JOB_NONE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == rars_pkg::ST_CLEAR) begin
                r_clr <= r_clr + IW'(1);
            end
            if (cfg_wr) begin
                r_size <= pwdata[SW-1:0];
                r_clr  <= '0;
            end
            if (o_out.valid && o_out.ready) begin
                r_ov <= 1'b0;
            end
            if (in_xfer) begin
                r_step <= '0;
                r_job  <= rars_pkg::JOB_NONE;
                if (lo_ok) begin
                    case (i_in.func)
                        rars_pkg::FUNC_LOAD: r_job <= rars_pkg::JOB_LOAD;
                        rars_pkg::FUNC_ADD: begin
                            r_job <= rars_pkg::JOB_ADD;
                            if (rng_empty) begin
                                r_step <= 3'd2;
                            end
                        end
                        rars_pkg::FUNC_SUM: begin
                            if (!rng_empty) begin
                                r_job <= rars_pkg::JOB_SUM;
                            end
                        end
                        default: r_job <= rars_pkg::JOB_NONE;
                    endcase
                end
            end
            if (r_state == rars_pkg::ST_PLAN && plan_act == rars_pkg::ACT_FINISH
                && out_free) begin
                r_ov <= 1'b1;
            end
            if ((r_state == rars_pkg::ST_PF_SUB) ||
                (r_state == rars_pkg::ST_UP_RD && r_j > BW'(rars_pkg::MAX_ELEMENTS))) begin
                r_step <= r_step + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_lo <= i_in.lo;
            r_r  <= hi_clip;
            r_n  <= sz_use;
            r_v  <= DW'(i_in.value);
        end
        case (r_state)
            rars_pkg::ST_PLAN: begin
                if (r_step == 3'd1) begin
                    r_pa <= r_pval;
                end
                r_uidx <= plan_idx;
                r_j    <= plan_idx;
                r_dlt  <= plan_dlt;
                r_acc1 <= '0;
                r_acc2 <= '0;
                if (plan_act == rars_pkg::ACT_FINISH && out_free) begin
                    r_out <= plan_res;
                end
            end
            rars_pkg::ST_PF_ACC: begin
                r_acc1 <= r_acc1 + r_rd[DW-1:0];
                r_acc2 <= r_acc2 + r_rd[2*DW-1:DW];
                r_j    <= r_j - j_low;
            end
            rars_pkg::ST_PF_MUL: r_prod <= mul_p[DW-1:0];
            rars_pkg::ST_PF_SUB: r_pval <= r_prod - r_acc2;
            rars_pkg::ST_UP_MUL: r_prod <= mul_p[DW-1:0];
            rars_pkg::ST_UP_WR:  r_j    <= r_j + j_low;
            default: r_j <= r_j;
        endcase
    end

endmodule
